// ===== src/sparse_csc_scatter_add_defines.svh =====
// Assertion macros for the CSC scatter-add block.
// Included by the top level; relies on signals named clk and rst at the point of use.
`ifndef SPARSE_CSC_SCATTER_ADD_DEFINES_SVH
`define SPARSE_CSC_SCATTER_ADD_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is high.
`define SCSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that also holds during reset.
`define SCSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCSA_ASSERT(lbl, prop, msg)
`define SCSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== src/scsa_pkg.sv =====
// Shared types, sizes and codes of the CSC scatter-add block.
// No dependencies; every other RTL file but scsa_ram imports it.
`default_nettype none
package scsa_pkg;

  localparam int MAX_EQUATIONS = 4096;
  localparam int MAX_NONZEROS  = 65536;

  localparam int NZ_AW  = $clog2(MAX_NONZEROS);
  localparam int PTR_W  = $clog2(MAX_NONZEROS + 1);
  localparam int CS_AW  = $clog2(MAX_EQUATIONS + 1);
  localparam int ROW_W  = $clog2(MAX_EQUATIONS);

  localparam int KIND_W = 3;
  localparam int ADDR_W = 17;
  localparam int WORD_W = 17;
  localparam int NUM_W  = 16;
  localparam int DBL_W  = 64;
  localparam int SLOT_W = 16;
  localparam int CFG_W  = 13;

  localparam logic [KIND_W-1:0] KIND_LOAD_START = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_ROW   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ADD        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

  localparam logic [DBL_W-1:0] DBL_ONE     = 64'h3FF0_0000_0000_0000;
  localparam logic [DBL_W-1:0] DBL_NEG_ONE = 64'hBFF0_0000_0000_0000;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [ADDR_W-1:0]       address;
    logic [WORD_W-1:0]       table_word;
    logic signed [NUM_W-1:0] row_number;
    logic signed [NUM_W-1:0] column_number;
    logic [DBL_W-1:0]        entry_value;
    logic [DBL_W-1:0]        scale_factor;
  } scsa_in_t;

  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] slot;
    logic [DBL_W-1:0]  read_value;
  } scsa_out_t;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD_START, OP_LOAD_ROW, OP_CLEAR, OP_ADD, OP_READ
  } op_t;

  typedef enum logic [1:0] {
    FM_MAC, FM_ADD, FM_SUB
  } fmode_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic [ROW_W-1:0]  row;
    logic [ROW_W-1:0]  col;
    fmode_t            mode;
    logic [DBL_W-1:0]  value;
    logic [DBL_W-1:0]  factor;
  } cmd_t;

  // Queue head seen by the back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fe_head_t;

  // Status returned by the back end.
  typedef struct packed {
    logic pop;
    logic init_busy;
  } bk_stat_t;

  typedef struct packed {
    logic             start;
    fmode_t           mode;
    logic [DBL_W-1:0] stored;
    logic [DBL_W-1:0] entry;
    logic [DBL_W-1:0] factor;
  } fpu_req_t;

  typedef struct packed {
    logic             done;
    logic [DBL_W-1:0] result;
  } fpu_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE, B_EXEC, B_CLEAR, B_CS0, B_CS1, B_SRCH, B_SCMP, B_FIN, B_FCMP,
    B_VWAIT, B_FPU, B_RDWAIT, B_DONE
  } bk_state_t;

  typedef enum logic [3:0] {
    F_IDLE, F_MSPEC, F_MUL, F_NORM, F_SHR, F_PACK, F_AUNP, F_ASUM, F_DONE
  } fpu_state_t;

endpackage
`default_nettype wire

// ===== src/sparse_csc_scatter_add.sv =====
// Top level of the CSC scatter-add block: front end, back end and checks.
// Depends on scsa_pkg, scsa_front, scsa_back and sparse_csc_scatter_add_defines.svh.
//
//   channel   direction  payload                         handshake
//   in        input      scsa_in_t (kind .. factor)      in_valid / in_ready
//   out       output     scsa_out_t (found, slot, value) out_valid / out_ready
//   cfg       input      equation_count, 13 bits         cfg_valid / cfg_ready
//
// Loads and skipped requests go from execute to done, reads also wait on the value memory,
// and a clear writes every value-memory row, one row per cycle; out_valid is set from the
// done state once the output register is free. An add that reaches the search reads the
// column pointers, takes k <= floor(log2(n)) + 1 halving steps over n column slots and, on
// a hit, runs the multiply-add unit, which skips the multiply for special operands and a
// unit factor. After reset a clearing pass holds in_ready low; the queue holds two requests.
`default_nettype none
`include "sparse_csc_scatter_add_defines.svh"
module sparse_csc_scatter_add (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire scsa_pkg::scsa_in_t         in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output scsa_pkg::scsa_out_t             out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [scsa_pkg::CFG_W-1:0] cfg_data
);
  import scsa_pkg::*;

  fe_head_t head;
  bk_stat_t bk_stat;

  scsa_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .stat(bk_stat), .head(head)
  );

  scsa_back u_back (
    .clk(clk), .rst(rst),
    .head(head), .stat(bk_stat),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // A hit never carries read data, and a miss never carries a slot.
  `SCSA_ASSERT(a_hit_no_read, out_valid && out_data.found |-> out_data.read_value == 64'd0, "hit with read data")
  `SCSA_ASSERT(a_miss_no_slot, out_valid && !out_data.found |-> out_data.slot == '0, "miss with slot")
  // No request is taken while the value store is being cleared after reset.
  `SCSA_ASSERT(a_init_blocks, bk_stat.init_busy |-> !in_ready, "request taken during init")
  `SCSA_ASSERT_ALWAYS(a_reset_init, rst |=> bk_stat.init_busy, "no clearing pass after reset")

endmodule
`default_nettype wire

// ===== src/scsa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module scsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/scsa_fpu.sv =====
// Multi-cycle double-precision multiply-accumulate, add or subtract with round to nearest even.
// Depends on scsa_pkg.
`default_nettype none
module scsa_fpu (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire scsa_pkg::fpu_req_t req,
  output scsa_pkg::fpu_rsp_t      rsp
);
  import scsa_pkg::*;

  localparam logic [DBL_W-1:0] DNAN = 64'hFFF8_0000_0000_0000;

  function automatic logic f_nan(input logic [DBL_W-1:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic f_inf(input logic [DBL_W-1:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
  endfunction

  function automatic logic f_zero(input logic [DBL_W-1:0] x);
    return x[62:0] == 63'd0;
  endfunction

  function automatic logic [52:0] f_mant(input logic [DBL_W-1:0] x);
    return {x[62:52] != 11'd0, x[51:0]};
  endfunction

  function automatic logic [10:0] f_exp(input logic [DBL_W-1:0] x);
    return (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
  endfunction

  function automatic logic [DBL_W-1:0] f_quiet(input logic [DBL_W-1:0] x);
    return x | 64'h0008_0000_0000_0000;
  endfunction

  fpu_state_t state, state_next;

  logic [DBL_W-1:0]  s_bits, v_bits, f_bits, p_bits, res;
  logic              sub, phase, sgn, ovf, eff_sub;
  logic [52:0]       ma, mb;
  logic [2:0]        mcnt;
  logic [53:0]       pp;
  logic [105:0]      acc;
  logic [127:0]      m, xb, xs;
  logic signed [13:0] e;
  logic [10:0]       beadj;

  // Multiply special cases.
  logic              m_special;
  logic [DBL_W-1:0]  m_special_bits;
  logic              m_sx;

  always_comb begin
    m_sx           = f_bits[63] ^ v_bits[63];
    m_special      = 1'b1;
    m_special_bits = {m_sx, 63'd0};
    if (f_nan(f_bits)) begin
      m_special_bits = f_quiet(f_bits);
    end else if (f_nan(v_bits)) begin
      m_special_bits = f_quiet(v_bits);
    end else if ((f_inf(f_bits) && f_zero(v_bits)) || (f_zero(f_bits) && f_inf(v_bits))) begin
      m_special_bits = DNAN;
    end else if (f_inf(f_bits) || f_inf(v_bits)) begin
      m_special_bits = {m_sx, 11'h7FF, 52'd0};
    end else if (f_zero(f_bits) || f_zero(v_bits)) begin
      m_special_bits = {m_sx, 63'd0};
    end else begin
      m_special = 1'b0;
    end
  end

  // Partial product operands: low and high halves of each mantissa.
  logic [26:0] opa, opb;
  logic [6:0]  pshift;

  always_comb begin
    opa = (mcnt == 3'd0 || mcnt == 3'd1) ? ma[26:0] : {1'b0, ma[52:27]};
    opb = (mcnt == 3'd0 || mcnt == 3'd2) ? mb[26:0] : {1'b0, mb[52:27]};
    case (mcnt)
      3'd1:    pshift = 7'd0;
      3'd2:    pshift = 7'd27;
      3'd3:    pshift = 7'd27;
      3'd4:    pshift = 7'd54;
      default: pshift = 7'd0;
    endcase
  end

  // Addition operand unpacking and alignment.
  logic              a_special;
  logic [DBL_W-1:0]  a_special_bits;
  logic              ys, big_x;
  logic [52:0]       mx, my;
  logic [10:0]       ex, ey, ebig, d;
  logic [127:0]      xsmall, small_sh, small_mask;

  always_comb begin
    ys             = p_bits[63] ^ sub;
    a_special      = 1'b1;
    a_special_bits = s_bits;
    if (f_nan(s_bits)) begin
      a_special_bits = f_quiet(s_bits);
    end else if (f_nan(p_bits)) begin
      a_special_bits = f_quiet(p_bits);
    end else if (f_inf(s_bits) && f_inf(p_bits)) begin
      a_special_bits = (s_bits[63] != ys) ? DNAN : s_bits;
    end else if (f_inf(s_bits)) begin
      a_special_bits = s_bits;
    end else if (f_inf(p_bits)) begin
      a_special_bits = {ys, p_bits[62:0]};
    end else if (f_zero(s_bits) && f_zero(p_bits)) begin
      a_special_bits = {s_bits[63] & ys, 63'd0};
    end else begin
      a_special = 1'b0;
    end
    mx     = f_mant(s_bits);
    my     = f_mant(p_bits);
    ex     = f_exp(s_bits);
    ey     = f_exp(p_bits);
    big_x  = (ex > ey) || ((ex == ey) && (mx >= my));
    ebig   = big_x ? ex : ey;
    d      = big_x ? (ex - ey) : (ey - ex);
    xsmall = big_x ? {1'b0, my, 74'd0} : {1'b0, mx, 74'd0};
    if (d[10:7] != 4'd0) begin
      small_sh = {127'd0, xsmall != 128'd0};
    end else begin
      small_mask = (128'd1 << d[6:0]) - 128'd1;
      small_sh   = (xsmall >> d[6:0]) | {127'd0, (xsmall & small_mask) != 128'd0};
    end
    if (d[10:7] == 4'd0) begin
      small_mask = (128'd1 << d[6:0]) - 128'd1;
    end else begin
      small_mask = '1;
    end
  end

  // Exponent handling before packing.
  logic signed [13:0] be, shr;
  logic [127:0]       m_sub, sub_mask;
  logic [127:0]       sum;

  always_comb begin
    be       = e + 14'sd1022;
    shr      = 14'sd1 - be;
    sub_mask = (128'd1 << shr[6:0]) - 128'd1;
    if (shr > 14'sd127) begin
      m_sub = {127'd0, m != 128'd0};
    end else begin
      m_sub = (m >> shr[6:0]) | {127'd0, (m & sub_mask) != 128'd0};
    end
    sum = eff_sub ? (xb - xs) : (xb + xs);
  end

  // Rounding and packing.
  logic        rnd_inc;
  logic [62:0] body;
  logic [DBL_W-1:0] packed_bits;

  always_comb begin
    rnd_inc     = m[74] & ((m[73:0] != 74'd0) | m[75]);
    body        = {beadj, 52'd0} + {10'd0, m[127:75]} + {62'd0, rnd_inc};
    packed_bits = ovf ? {sgn, 11'h7FF, 52'd0} : {sgn, body};
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (req.start) state_next = (req.mode == FM_MAC) ? F_MSPEC : F_AUNP;
      F_MSPEC: state_next = m_special ? F_AUNP : F_MUL;
      F_MUL:   if (mcnt == 3'd5) state_next = F_NORM;
      F_NORM:  if (m[127]) state_next = F_SHR;
      F_SHR:   state_next = F_PACK;
      F_PACK:  state_next = phase ? F_DONE : F_AUNP;
      F_AUNP:  state_next = a_special ? F_DONE : F_ASUM;
      F_ASUM:  state_next = (sum == 128'd0) ? F_DONE : F_NORM;
      F_DONE:  state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    rsp.done   = (state == F_DONE);
    rsp.result = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        s_bits <= req.stored;
        v_bits <= req.entry;
        f_bits <= req.factor;
        p_bits <= req.entry;
        sub    <= (req.mode == FM_SUB);
      end
      F_MSPEC: begin
        sub    <= 1'b0;
        p_bits <= m_special_bits;
        ma     <= f_mant(f_bits);
        mb     <= f_mant(v_bits);
        e      <= $signed({3'd0, f_exp(f_bits)}) + $signed({3'd0, f_exp(v_bits)})
                  - 14'sd2044;
        sgn    <= m_sx;
        acc    <= '0;
        mcnt   <= 3'd0;
        phase  <= 1'b0;
      end
      F_MUL: begin
        pp   <= opa * opb;
        mcnt <= mcnt + 3'd1;
        if (mcnt != 3'd0 && mcnt != 3'd5) begin
          acc <= acc + ({52'd0, pp} << pshift);
        end
        if (mcnt == 3'd5) begin
          m <= {acc, 22'd0};
        end
      end
      F_NORM: begin
        if (m[127:112] == 16'd0) begin
          m <= m << 16;
          e <= e - 14'sd16;
        end else if (!m[127]) begin
          m <= m << 1;
          e <= e - 14'sd1;
        end
      end
      F_SHR: begin
        ovf <= (be >= 14'sd2047);
        if (be >= 14'sd1) begin
          beadj <= be[10:0] - 11'd1;
        end else begin
          beadj <= 11'd0;
          m     <= m_sub;
        end
      end
      F_PACK: begin
        if (phase) begin
          res <= packed_bits;
        end else begin
          p_bits <= packed_bits;
        end
      end
      F_AUNP: begin
        res     <= a_special_bits;
        xb      <= big_x ? {1'b0, mx, 74'd0} : {1'b0, my, 74'd0};
        xs      <= small_sh;
        eff_sub <= (s_bits[63] != ys);
        sgn     <= big_x ? s_bits[63] : ys;
        e       <= $signed({3'd0, ebig}) - 14'sd1021;
      end
      F_ASUM: begin
        res   <= '0;
        m     <= sum;
        phase <= 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== src/scsa_front.sv =====
// Front end: configuration register, item classification and a two-entry queue.
// Depends on scsa_pkg.
`default_nettype none
module scsa_front (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire scsa_pkg::scsa_in_t       in_data,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [scsa_pkg::CFG_W-1:0] cfg_data,
  input  wire scsa_pkg::bk_stat_t       stat,
  output scsa_pkg::fe_head_t            head
);
  import scsa_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  logic [CFG_W-1:0] equation_count;
  logic [CFG_W-1:0] limit;
  cmd_t             q [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QAW:0]     cnt;
  cmd_t             cls;
  logic             push, row_ok, col_ok, fact_zero;

  assign cfg_ready = 1'b1;

  // Equation count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      equation_count <= '0;
    end else if (cfg_valid) begin
      equation_count <= cfg_data;
    end
  end

  // Decode one request into a command for the back end.
  always_comb begin
    limit     = (equation_count > CFG_W'(MAX_EQUATIONS)) ? CFG_W'(MAX_EQUATIONS)
                                                         : equation_count;
    row_ok    = !in_data.row_number[NUM_W-1]
                && ({1'b0, in_data.row_number[NUM_W-2:0]} < NUM_W'(limit));
    col_ok    = !in_data.column_number[NUM_W-1]
                && ({1'b0, in_data.column_number[NUM_W-2:0]} < NUM_W'(limit));
    fact_zero = (in_data.scale_factor[DBL_W-2:0] == '0);
    cls.addr   = in_data.address;
    cls.word   = in_data.table_word;
    cls.row    = ROW_W'(in_data.row_number);
    cls.col    = ROW_W'(in_data.column_number);
    cls.value  = in_data.entry_value;
    cls.factor = in_data.scale_factor;
    if (in_data.scale_factor == DBL_ONE) begin
      cls.mode = FM_ADD;
    end else if (in_data.scale_factor == DBL_NEG_ONE) begin
      cls.mode = FM_SUB;
    end else begin
      cls.mode = FM_MAC;
    end
    case (in_data.kind)
      KIND_LOAD_START:
        cls.op = (in_data.address <= ADDR_W'(MAX_EQUATIONS)) ? OP_LOAD_START : OP_NOP;
      KIND_LOAD_ROW:
        cls.op = (in_data.address < ADDR_W'(MAX_NONZEROS)) ? OP_LOAD_ROW : OP_NOP;
      KIND_CLEAR:
        cls.op = OP_CLEAR;
      KIND_ADD:
        cls.op = (row_ok && col_ok && !fact_zero) ? OP_ADD : OP_NOP;
      KIND_READ:
        cls.op = (in_data.address < ADDR_W'(MAX_NONZEROS)) ? OP_READ : OP_NOP;
      default:
        cls.op = OP_NOP;
    endcase
  end

  // Queue between front and back.
  assign in_ready   = (cnt != (QAW+1)'(QDEPTH)) && !stat.init_busy;
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt != '0);
  assign head.cmd   = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (stat.pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(stat.pop);
    end
  end

endmodule
`default_nettype wire

// ===== src/scsa_back.sv =====
// Back end: pattern and value memories, row search sequencer and result register.
// Depends on scsa_pkg, scsa_ram and scsa_fpu.
`default_nettype none
module scsa_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire scsa_pkg::fe_head_t head,
  output scsa_pkg::bk_stat_t      stat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output scsa_pkg::scsa_out_t     out_data
);
  import scsa_pkg::*;

  bk_state_t state, state_next;

  cmd_t             cur;
  scsa_out_t        res;
  logic [PTR_W-1:0] lo, hi, first, count, step, it;
  logic [NZ_AW-1:0] clr_addr;
  logic             clr_init;
  logic             clr_last, out_free;
  logic [PTR_W-1:0] cs_clamped;

  logic             cs_we, row_we, val_we;
  logic [CS_AW-1:0] cs_waddr, cs_raddr;
  logic [PTR_W-1:0] cs_wdata, cs_rdata;
  logic [NZ_AW-1:0] row_waddr, row_raddr, val_waddr, val_raddr;
  logic [ROW_W-1:0] row_wdata, row_rdata;
  logic [DBL_W-1:0] val_wdata, val_rdata;

  fpu_req_t fpu_req;
  fpu_rsp_t fpu_rsp;

  scsa_ram #(.WIDTH(PTR_W), .DEPTH(MAX_EQUATIONS + 1)) u_cs_ram (
    .clk(clk), .we(cs_we), .waddr(cs_waddr), .wdata(cs_wdata),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  scsa_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NONZEROS)) u_row_ram (
    .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  scsa_ram #(.WIDTH(DBL_W), .DEPTH(MAX_NONZEROS)) u_val_ram (
    .clk(clk), .we(val_we), .waddr(val_waddr), .wdata(val_wdata),
    .raddr(val_raddr), .rdata(val_rdata)
  );

  scsa_fpu u_fpu (.clk(clk), .rst(rst), .req(fpu_req), .rsp(fpu_rsp));

  // Search arithmetic and helpers.
  always_comb begin
    step       = count >> 1;
    it         = first + step;
    clr_last   = (clr_addr == NZ_AW'(MAX_NONZEROS - 1));
    out_free   = !out_valid || out_ready;
    cs_clamped = (cs_rdata > PTR_W'(MAX_NONZEROS)) ? PTR_W'(MAX_NONZEROS) : cs_rdata;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:  if (head.valid) state_next = B_EXEC;
      B_EXEC: begin
        case (cur.op)
          OP_CLEAR: state_next = B_CLEAR;
          OP_ADD:   state_next = B_CS0;
          OP_READ:  state_next = B_RDWAIT;
          default:  state_next = B_DONE;
        endcase
      end
      B_CLEAR: if (clr_last) state_next = clr_init ? B_IDLE : B_DONE;
      B_CS0:   state_next = B_CS1;
      B_CS1:   state_next = (cs_clamped <= lo) ? B_DONE : B_SRCH;
      B_SRCH: begin
        if (count != '0) begin
          state_next = B_SCMP;
        end else begin
          state_next = (first < hi) ? B_FIN : B_DONE;
        end
      end
      B_SCMP:  state_next = B_SRCH;
      B_FIN:   state_next = B_FCMP;
      B_FCMP:  state_next = (row_rdata == cur.row) ? B_VWAIT : B_DONE;
      B_VWAIT: state_next = B_FPU;
      B_FPU:   if (fpu_rsp.done) state_next = B_DONE;
      B_RDWAIT: state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  // Memory, queue and arithmetic unit controls.
  always_comb begin
    stat.pop       = (state == B_IDLE) && head.valid;
    stat.init_busy = (state == B_CLEAR) && clr_init;
    cs_we     = (state == B_EXEC) && (cur.op == OP_LOAD_START);
    cs_waddr  = CS_AW'(cur.addr);
    cs_wdata  = PTR_W'(cur.word);
    cs_raddr  = (state == B_EXEC) ? CS_AW'(cur.col) : CS_AW'(cur.col) + CS_AW'(1);
    row_we    = (state == B_EXEC) && (cur.op == OP_LOAD_ROW);
    row_waddr = NZ_AW'(cur.addr);
    row_wdata = ROW_W'(cur.word);
    row_raddr = (state == B_SRCH) ? NZ_AW'(it) : NZ_AW'(first);
    val_we    = (state == B_CLEAR) || ((state == B_FPU) && fpu_rsp.done);
    val_waddr = (state == B_CLEAR) ? clr_addr : NZ_AW'(first);
    val_wdata = (state == B_CLEAR) ? '0 : fpu_rsp.result;
    val_raddr = (state == B_EXEC) ? NZ_AW'(cur.addr) : NZ_AW'(first);
    fpu_req.start  = (state == B_VWAIT);
    fpu_req.mode   = cur.mode;
    fpu_req.stored = val_rdata;
    fpu_req.entry  = cur.value;
    fpu_req.factor = cur.factor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_CLEAR;
      clr_init <= 1'b1;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + NZ_AW'(1);
        if (clr_last) begin
          clr_init <= 1'b0;
        end
      end else if (state == B_EXEC) begin
        clr_addr <= '0;
      end
    end
  end

  // Working registers of the current command.
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: cur <= head.cmd;
      B_EXEC: res <= '0;
      B_CS0:  lo  <= cs_clamped;
      B_CS1: begin
        hi    <= cs_clamped;
        first <= lo;
        count <= cs_clamped - lo;
      end
      B_SCMP: begin
        if (row_rdata < cur.row) begin
          first <= it + PTR_W'(1);
          count <= count - step - PTR_W'(1);
        end else begin
          count <= step;
        end
      end
      B_FPU: begin
        if (fpu_rsp.done) begin
          res.found <= 1'b1;
          res.slot  <= SLOT_W'(first);
        end
      end
      B_RDWAIT: res.read_value <= val_rdata;
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == B_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == B_DONE) && out_free) begin
      out_data <= res;
    end
  end

endmodule
`default_nettype wire
